// ===== src/iso_contour_marker_top_macros.svh =====
// assertion macros used by the top module to check its own logic
`ifndef ISO_CONTOUR_MARKER_TOP_MACROS_SVH
`define ISO_CONTOUR_MARKER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ICM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ICM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/iso_cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_cm_pkg
// shared types and constants of the contour marker
// ----------------------------------------------------------------------------
package iso_cm_pkg;

   localparam int MAX_WIDTH_DEF      = 2048;
   localparam int MAX_HEIGHT_DEF     = 2048;
   localparam int ELEVATION_BITS_DEF = 24;

   localparam int PIXEL_W   = 11;
   localparam int CFG_DIM_W = 12;
   localparam int SPACING_W = 23;
   localparam int MINORS_W  = 8;
   localparam int COLOR_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [CFG_DIM_W-1:0] WIDTH_RST   = 12'd256;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RST  = 12'd256;
   localparam logic [SPACING_W-1:0] SPACING_RST = 23'd25600;
   localparam logic [MINORS_W-1:0]  MINORS_RST  = 8'd5;
   localparam logic [COLOR_W-1:0]   MINOR_RST   = 32'hFF80_8080;
   localparam logic [COLOR_W-1:0]   MAJOR_RST   = 32'hFF00_0000;
   localparam logic [COLOR_W-1:0]   ALPHA_FULL  = 32'hFF00_0000;
   localparam logic [COLOR_W-1:0]   CLEAR_COLOR = 32'h0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_MAJOR_SPACE  = 3'd2,
      CSR_MINORS       = 3'd3,
      CSR_MINOR_COLOR  = 3'd4,
      CSR_MAJOR_COLOR  = 3'd5
   } csr_index_type;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_MUL,
      S_QSTART,
      S_QWAIT,
      S_RSTART,
      S_RWAIT,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/iso_contour_marker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_contour_marker_top
// contour line marker for a raster elevation stream
// ----------------------------------------------------------------------------
// Samples (command push) arrive in raster order; each gets a band number
// trunc(elevation * n / major_spacing) and a major flag, kept in a three-row
// band memory. Pixels come out one row late as ARGB: a horizontal band change
// gives the line colour with full alpha, else a vertical change gives the line
// colour with its own alpha, else transparent black. After the last row, one
// flush transaction per pixel drains it; last_pixel marks the frame end. One
// transaction is handled at a time: a push runs the bit-serial divider twice
// (band quotient, then band mod n), a flush does four sequential reads of the
// band memory. Ignored transactions are accepted and dropped. The band memory
// has no reset; every entry whose value is used was written earlier in the
// frame.
module iso_contour_marker_top #(
   parameter int MAX_WIDTH      = iso_cm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT     = iso_cm_pkg::MAX_HEIGHT_DEF,
   parameter int ELEVATION_BITS = iso_cm_pkg::ELEVATION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transactions
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [ELEVATION_BITS-1:0]    req_elevation,
   // result transactions
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [iso_cm_pkg::PIXEL_W-1:0]      rsp_pixel_x,
   output logic [iso_cm_pkg::PIXEL_W-1:0]      rsp_pixel_y,
   output logic [7:0]                          rsp_red,
   output logic [7:0]                          rsp_green,
   output logic [7:0]                          rsp_blue,
   output logic [7:0]                          rsp_alpha,
   output logic                                rsp_last_pixel,
   // configuration writes
   input  logic                                csr_write,
   input  logic [iso_cm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [iso_cm_pkg::CSR_DAT_W-1:0]    csr_wdata
);

`include "iso_contour_marker_top_macros.svh"

   localparam int PW    = iso_cm_pkg::PIXEL_W;
   localparam int DW    = iso_cm_pkg::CFG_DIM_W;
   localparam int SW    = iso_cm_pkg::SPACING_W;
   localparam int NW    = iso_cm_pkg::MINORS_W;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int CWW   = (WW > DW) ? WW : DW;
   localparam int CWH   = (RW > DW) ? RW : DW;
   localparam int MW    = ELEVATION_BITS + 8;   // signed band / product width
   localparam int EW    = MW + 1;               // memory entry: major flag + band
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   // configuration registers
   logic [DW-1:0]                 cfg_width_ff, cfg_height_ff;
   logic [SW-1:0]                 cfg_spacing_ff;
   logic [NW-1:0]                 cfg_minors_ff;
   logic [iso_cm_pkg::COLOR_W-1:0] cfg_minor_ff, cfg_major_ff;

   // control state
   iso_cm_pkg::state_type state_ff, state_in;
   logic [XW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]    rot_ff, rot_in;
   logic [2:0]    rd_cnt_ff, rd_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic                     cmd_ff, cmd_in;
   logic signed [ELEVATION_BITS-1:0] elev_ff, elev_in;
   logic signed [MW-1:0]     prod_ff, prod_in;
   logic signed [MW-1:0]     band_ff, band_in;
   logic                     major_ff, major_in;
   logic [EW-1:0]            me_ff, me_in, rt_ff, rt_in, lf_ff, lf_in, up_ff, up_in;
   logic [PW-1:0]            out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [iso_cm_pkg::COLOR_W-1:0] out_color_ff, out_color_in;
   logic                     out_last_ff, out_last_in;

   // effective geometry and derived values
   logic [CWW-1:0] w_ext;
   logic [CWH-1:0] h_ext;
   logic [WW-1:0]  w_eff;
   logic [RW-1:0]  h_eff;
   logic [SW-1:0]  spacing_eff;
   logic [NW-1:0]  minors_eff;
   logic [WW-1:0]  x_p1;
   logic           rt_ok, lf_ok, up_ok, lo_ok;
   logic           row_end, emit, load;
   logic [1:0]     cur_slot, up_slot;
   logic [EW+MW-1:0] prod_full;
   logic [MW-1:0]  prod_mag;
   logic [EW-1:0]  lo_entry;

   // memory and divider hookup
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_rdata;
   logic [XW-1:0] rd_x;
   logic [1:0]    rd_slot;
   logic          div_start;
   logic [MW-1:0] div_num, div_quot;
   logic [SW-1:0] div_den, div_rem;
   iso_cm_pkg::div_status_type div_st;

   // colour choice
   logic          h_hit, h_maj, v_hit, v_maj;
   logic [iso_cm_pkg::COLOR_W-1:0] color;

   // ------------------------------------------------------------------------
   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff   <= iso_cm_pkg::WIDTH_RST;
         cfg_height_ff  <= iso_cm_pkg::HEIGHT_RST;
         cfg_spacing_ff <= iso_cm_pkg::SPACING_RST;
         cfg_minors_ff  <= iso_cm_pkg::MINORS_RST;
         cfg_minor_ff   <= iso_cm_pkg::MINOR_RST;
         cfg_major_ff   <= iso_cm_pkg::MAJOR_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            iso_cm_pkg::CSR_IMAGE_WIDTH:  cfg_width_ff   <= csr_wdata[DW-1:0];
            iso_cm_pkg::CSR_IMAGE_HEIGHT: cfg_height_ff  <= csr_wdata[DW-1:0];
            iso_cm_pkg::CSR_MAJOR_SPACE:  cfg_spacing_ff <= csr_wdata[SW-1:0];
            iso_cm_pkg::CSR_MINORS:       cfg_minors_ff  <= csr_wdata[NW-1:0];
            iso_cm_pkg::CSR_MINOR_COLOR:  cfg_minor_ff   <= csr_wdata;
            iso_cm_pkg::CSR_MAJOR_COLOR:  cfg_major_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp geometry, zero spacing or n counts as one
   always_comb begin
      w_ext = CWW'(cfg_width_ff);
      h_ext = CWH'(cfg_height_ff);
      if (w_ext == '0) begin
         w_eff = WW'(1);
      end else if (w_ext > CWW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_ext);
      end
      if (h_ext == '0) begin
         h_eff = RW'(1);
      end else if (h_ext > CWH'(MAX_HEIGHT)) begin
         h_eff = RW'(MAX_HEIGHT);
      end else begin
         h_eff = RW'(h_ext);
      end
      spacing_eff = (cfg_spacing_ff == '0) ? SW'(1) : cfg_spacing_ff;
      minors_eff  = (cfg_minors_ff == '0) ? NW'(1) : cfg_minors_ff;
   end

   // ------------------------------------------------------------------------
   // neighbour bookkeeping
   always_comb begin
      x_p1     = WW'(col_ff) + WW'(1);
      rt_ok    = (x_p1 < w_eff);
      lf_ok    = (col_ff != '0) && (WW'(col_ff) <= w_eff);
      up_ok    = (row_ff >= RW'(2));
      lo_ok    = (cmd_ff == iso_cm_pkg::CMD_PUSH);
      row_end  = (x_p1 >= w_eff);
      // slot of the emitted row and the one above it
      cur_slot = (rot_ff == 2'd0) ? 2'd2 : rot_ff - 2'd1;
      up_slot  = (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
      emit     = (cmd_ff == iso_cm_pkg::CMD_FLUSH) || (row_ff != '0);
      load     = (state_ff == iso_cm_pkg::S_DONE) && emit
                 && (!rsp_valid_ff || !rsp_stall);
   end

   // read sequence: right, left, center of the emitted row, then the row above
   always_comb begin
      rd_x    = col_ff;
      rd_slot = cur_slot;
      case (rd_cnt_ff)
         3'd0: rd_x = rt_ok ? x_p1[XW-1:0] : col_ff;
         3'd1: rd_x = (col_ff != '0) ? col_ff - XW'(1) : col_ff;
         3'd3: rd_slot = up_slot;
         default: ;
      endcase
   end

   function automatic logic [AW-1:0] slot_addr(input logic [1:0] slot,
                                               input logic [XW-1:0] x);
      logic [AW-1:0] base;
      case (slot)
         2'd1:    base = AW'(MAX_WIDTH);
         2'd2:    base = AW'(2 * MAX_WIDTH);
         default: base = '0;
      endcase
      return base + AW'(x);
   endfunction

   assign ram_raddr = slot_addr(rd_slot, rd_x);
   assign ram_waddr = slot_addr(rot_ff, col_ff);
   assign lo_entry  = {major_ff, band_ff};

   iso_cm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_band_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (lo_entry),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   iso_cm_div #(
      .NUM_W (MW),
      .DEN_W (SW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_st),
      .quot   (div_quot),
      .rem    (div_rem)
   );

   // ------------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iso_cm_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_command == iso_cm_pkg::CMD_PUSH) begin
                  if (row_ff < h_eff) state_in = iso_cm_pkg::S_READ;
               end else begin
                  if (row_ff >= h_eff) state_in = iso_cm_pkg::S_READ;
               end
            end
         end
         iso_cm_pkg::S_READ: begin
            if (rd_cnt_ff == 3'd4) begin
               state_in = (cmd_ff == iso_cm_pkg::CMD_FLUSH) ? iso_cm_pkg::S_DONE
                                                            : iso_cm_pkg::S_MUL;
            end
         end
         iso_cm_pkg::S_MUL:    state_in = iso_cm_pkg::S_QSTART;
         iso_cm_pkg::S_QSTART: state_in = iso_cm_pkg::S_QWAIT;
         iso_cm_pkg::S_QWAIT:  if (div_st.done) state_in = iso_cm_pkg::S_RSTART;
         iso_cm_pkg::S_RSTART: state_in = iso_cm_pkg::S_RWAIT;
         iso_cm_pkg::S_RWAIT:  if (div_st.done) state_in = iso_cm_pkg::S_WRITE;
         iso_cm_pkg::S_WRITE:  state_in = iso_cm_pkg::S_DONE;
         iso_cm_pkg::S_DONE: begin
            if (!emit || !rsp_valid_ff || !rsp_stall) state_in = iso_cm_pkg::S_IDLE;
         end
         default: state_in = iso_cm_pkg::S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      div_start = 1'b0;
      div_num   = prod_mag;
      div_den   = spacing_eff;
      unique case (state_ff)
         iso_cm_pkg::S_IDLE:   req_stall = 1'b0;
         iso_cm_pkg::S_QSTART: div_start = 1'b1;
         iso_cm_pkg::S_RSTART: begin
            div_start = 1'b1;
            div_num   = div_quot;
            div_den   = SW'(minors_eff);
         end
         iso_cm_pkg::S_WRITE:  ram_we = 1'b1;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // datapath: product, band, neighbour capture
   always_comb begin
      prod_full = $signed(elev_ff) * $signed({1'b0, minors_eff});
      prod_in   = prod_ff;
      prod_mag  = prod_ff[MW-1] ? MW'(-prod_ff) : MW'(prod_ff);
      cmd_in    = cmd_ff;
      elev_in   = elev_ff;
      band_in   = band_ff;
      major_in  = major_ff;
      me_in     = me_ff;
      rt_in     = rt_ff;
      lf_in     = lf_ff;
      up_in     = up_ff;
      rd_cnt_in = '0;
      if (state_ff == iso_cm_pkg::S_IDLE) begin
         cmd_in  = req_command;
         elev_in = req_elevation;
      end
      if (state_ff == iso_cm_pkg::S_READ) begin
         rd_cnt_in = rd_cnt_ff + 3'd1;
         case (rd_cnt_ff)
            3'd1:    rt_in = ram_rdata;
            3'd2:    lf_in = ram_rdata;
            3'd3:    me_in = ram_rdata;
            3'd4:    up_in = ram_rdata;
            default: ;
         endcase
      end
      if (state_ff == iso_cm_pkg::S_MUL) begin
         prod_in = prod_full[MW-1:0];
      end
      if (state_ff == iso_cm_pkg::S_QWAIT && div_st.done) begin
         band_in = prod_ff[MW-1] ? -$signed(div_quot) : $signed(div_quot);
      end
      if (state_ff == iso_cm_pkg::S_RWAIT && div_st.done) begin
         major_in = (div_rem == '0);
      end
   end

   // colour: horizontal change wins, right before left, lower before upper
   always_comb begin
      h_hit = 1'b0;
      h_maj = 1'b0;
      v_hit = 1'b0;
      v_maj = 1'b0;
      if (rt_ok && (me_ff[MW-1:0] != rt_ff[MW-1:0])) begin
         h_hit = 1'b1;
         h_maj = me_ff[MW] | rt_ff[MW];
      end else if (lf_ok && (me_ff[MW-1:0] != lf_ff[MW-1:0])) begin
         h_hit = 1'b1;
         h_maj = me_ff[MW] | lf_ff[MW];
      end
      if (lo_ok && (me_ff[MW-1:0] != band_ff)) begin
         v_hit = 1'b1;
         v_maj = me_ff[MW] | major_ff;
      end else if (up_ok && (me_ff[MW-1:0] != up_ff[MW-1:0])) begin
         v_hit = 1'b1;
         v_maj = me_ff[MW] | up_ff[MW];
      end
      if (h_hit) begin
         color = (h_maj ? cfg_major_ff : cfg_minor_ff) | iso_cm_pkg::ALPHA_FULL;
      end else if (v_hit) begin
         color = v_maj ? cfg_major_ff : cfg_minor_ff;
      end else begin
         color = iso_cm_pkg::CLEAR_COLOR;
      end
   end

   // counters and result register
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      rot_in       = rot_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_x_in     = PW'(col_ff);
         out_y_in     = PW'(row_ff - RW'(1));
         out_color_in = color;
         out_last_in  = (cmd_ff == iso_cm_pkg::CMD_FLUSH) && row_end;
      end
      if (state_ff == iso_cm_pkg::S_DONE && state_in == iso_cm_pkg::S_IDLE) begin
         if (cmd_ff == iso_cm_pkg::CMD_PUSH) begin
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
               rot_in = (rot_ff == 2'd2) ? 2'd0 : rot_ff + 2'd1;
            end else begin
               col_in = col_ff + XW'(1);
            end
         end else if (row_end) begin
            // frame done
            col_in = '0;
            row_in = '0;
            rot_in = 2'd0;
         end else begin
            col_in = col_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iso_cm_pkg::S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rot_ff       <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rot_ff       <= rot_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      elev_ff      <= elev_in;
      prod_ff      <= prod_in;
      band_ff      <= band_in;
      major_ff     <= major_in;
      me_ff        <= me_in;
      rt_ff        <= rt_in;
      lf_ff        <= lf_in;
      up_ff        <= up_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = out_x_ff;
   assign rsp_pixel_y    = out_y_ff;
   assign rsp_alpha      = out_color_ff[31:24];
   assign rsp_red        = out_color_ff[23:16];
   assign rsp_green      = out_color_ff[15:8];
   assign rsp_blue       = out_color_ff[7:0];
   assign rsp_last_pixel = out_last_ff;

   // ------------------------------------------------------------------------
   // checks
   `ICM_ASSERT_NOW(a_div_idle_start, clock, reset, div_start, !div_st.busy,
      "divider started while busy")
   `ICM_ASSERT_NEXT(a_hold_result, clock, reset,
      (state_ff == iso_cm_pkg::S_DONE) && emit && rsp_valid_ff && rsp_stall,
      state_ff == iso_cm_pkg::S_DONE, "pending pixel dropped while result held")
   `ICM_ASSERT_NOW(a_result_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == iso_cm_pkg::S_DONE, "result appeared outside completion")

endmodule

// ===== src/iso_cm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_cm_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module iso_cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/iso_cm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_cm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module iso_cm_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 23
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [NUM_W-1:0]               num,
   input  logic [DEN_W-1:0]               den,
   output iso_cm_pkg::div_status_type     status,
   output logic [NUM_W-1:0]               quot,
   output logic [DEN_W-1:0]               rem
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = CNT_W'(NUM_W);
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
      end else if (cnt_ff != '0) begin
         quot_in = {quot_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign quot        = quot_ff;
   assign rem         = rem_ff;

endmodule
